// ===== sv/fdf_pkg.sv =====
// Shared constants, types and control structs for the flood duplicate filter.
`timescale 1ns / 1ps

package fdf_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int SEQ_W  = 32;
    localparam int TIME_W = 32;
    localparam int OCC_W  = 7;

    // Register reset value
    localparam logic [TIME_W-1:0] AGE_LIMIT_RESET = TIME_W'(2000);

    // Item kinds
    localparam logic KIND_CHECK = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_TICK
    } fdf_state_t;

    // Lookup token travelling along the cell row
    typedef struct packed {
        logic valid;
        logic match;
    } fdf_tok_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic              shift;
        logic              write;
        logic [CNT_W-1:0]  count;
        logic [SEQ_W-1:0]  query;
        logic [TIME_W-1:0] now;
    } fdf_ctl_t;

endpackage

// ===== sv/fdf_cell.sv =====
// One table cell: holds an entry, compares the passing token and shifts toward the head.
`timescale 1ns / 1ps

module fdf_cell
    import fdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  slot,
    input  fdf_ctl_t          ctl,
    input  fdf_tok_t          tok_in,
    output fdf_tok_t          tok_out,
    input  logic [SEQ_W-1:0]  nbr_seq,
    input  logic [TIME_W-1:0] nbr_time,
    output logic [SEQ_W-1:0]  seq_q,
    output logic [TIME_W-1:0] time_q
);

    logic [SEQ_W-1:0]  seq_reg;
    logic [TIME_W-1:0] time_reg;
    fdf_tok_t          tok_reg;
    fdf_tok_t          tok_next;
    logic              held;
    logic              hit;

    // Compare only while this slot holds an entry
    assign held = (slot < ctl.count);
    assign hit  = held && (seq_reg == ctl.query);

    // Advance the token one cell, folding in this cell's match
    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.match = tok_in.match | (tok_in.valid & hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // Shift toward the head on removal, or load at the tail on insert
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            seq_reg  <= nbr_seq;
            time_reg <= nbr_time;
        end
        else if (ctl.write && (slot == ctl.count))
        begin
            seq_reg  <= ctl.query;
            time_reg <= ctl.now;
        end
    end

    assign tok_out = tok_reg;
    assign seq_q   = seq_reg;
    assign time_q  = time_reg;

endmodule

// ===== sv/flood_duplicate_filter_top.sv =====
// Top level: sequencer, age register and the row of table cells.
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------------------
//  item      in         start & !busy          kind, seq_number, now_time
//  result    out        done (one cycle)       is_duplicate, was_inserted, table_full,
//                                              entry_removed, removed_seq, occupancy
//  config    in         cfg_valid & cfg_ready  cfg_data (age_limit)
//
//  A check transaction walks a token through all TABLE_DEPTH cells, one cell per
//  cycle; its result is registered once the token leaves the last cell.
//  A tick transaction inspects only the head cell in state S_TICK, then registers its result.
//  busy is high from acceptance until the result strobe; a new item may be taken in
//  the strobe cycle. Reset empties the table and sets age_limit to 2000.
//  cfg_ready is always high. The receiver cannot stall results.
`timescale 1ns / 1ps

module flood_duplicate_filter_top
    import fdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              kind,
    input  logic [SEQ_W-1:0]  seq_number,
    input  logic [TIME_W-1:0] now_time,
    output logic              done,
    output logic              is_duplicate,
    output logic              was_inserted,
    output logic              table_full,
    output logic              entry_removed,
    output logic [SEQ_W-1:0]  removed_seq,
    output logic [OCC_W-1:0]  occupancy,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TIME_W-1:0] cfg_data
);

    fdf_state_t        state_reg, state_next;
    logic              inject_reg, inject_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SEQ_W-1:0]  query_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] age_limit_reg;
    logic              done_reg, done_next;
    logic              dup_reg, dup_next;
    logic              ins_reg, ins_next;
    logic              full_reg, full_next;
    logic              rem_reg, rem_next;
    logic [SEQ_W-1:0]  rseq_reg, rseq_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;

    logic              accept;
    logic              do_shift;
    logic              do_write;
    logic [TIME_W-1:0] head_age;
    fdf_ctl_t          ctl;

    fdf_tok_t          tok [TABLE_DEPTH+1];
    logic [SEQ_W-1:0]  cell_seq  [TABLE_DEPTH];
    logic [TIME_W-1:0] cell_time [TABLE_DEPTH];

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Broadcast control to the cells
    always_comb
    begin
        ctl.shift = do_shift;
        ctl.write = do_write;
        ctl.count = count_reg;
        ctl.query = query_reg;
        ctl.now   = now_reg;
    end

    // Launch the token into the first cell
    assign tok[0].valid = inject_reg;
    assign tok[0].match = 1'b0;

    // Row of cells; the last cell shifts in its own contents
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [SEQ_W-1:0]  nbr_seq;
        logic [TIME_W-1:0] nbr_time;

        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign nbr_seq  = cell_seq[i];
            assign nbr_time = cell_time[i];
        end
        else
        begin : g_mid
            assign nbr_seq  = cell_seq[i+1];
            assign nbr_time = cell_time[i+1];
        end

        fdf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot     (CNT_W'(i)),
            .ctl      (ctl),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1]),
            .nbr_seq  (nbr_seq),
            .nbr_time (nbr_time),
            .seq_q    (cell_seq[i]),
            .time_q   (cell_time[i])
        );
    end

    // Age of the oldest entry, modulo 2^32
    assign head_age = now_reg - cell_time[0];

    // Sequence the transaction and form the result
    always_comb
    begin
        state_next  = state_reg;
        inject_next = 1'b0;
        count_next  = count_reg;
        done_next   = 1'b0;
        dup_next    = dup_reg;
        ins_next    = ins_reg;
        full_next   = full_reg;
        rem_next    = rem_reg;
        rseq_next   = rseq_reg;
        occ_next    = occ_reg;
        do_shift    = 1'b0;
        do_write    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_TICK)
                    begin
                        state_next = S_TICK;
                    end
                    else
                    begin
                        state_next  = S_WALK;
                        inject_next = 1'b1;
                    end
                end
            end
            S_WALK:
            begin
                if (tok[TABLE_DEPTH].valid)
                begin
                    dup_next  = tok[TABLE_DEPTH].match;
                    ins_next  = 1'b0;
                    full_next = 1'b0;
                    rem_next  = 1'b0;
                    rseq_next = '0;
                    if (!tok[TABLE_DEPTH].match)
                    begin
                        if (count_reg < CNT_W'(TABLE_DEPTH))
                        begin
                            do_write   = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            ins_next   = 1'b1;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                    end
                    occ_next   = OCC_W'(count_next);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                dup_next  = 1'b0;
                ins_next  = 1'b0;
                full_next = 1'b0;
                rem_next  = 1'b0;
                rseq_next = '0;
                if ((count_reg != '0) && (head_age >= age_limit_reg))
                begin
                    do_shift   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    rem_next   = 1'b1;
                    rseq_next  = cell_seq[0];
                end
                occ_next   = OCC_W'(count_next);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            inject_reg    <= 1'b0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            age_limit_reg <= AGE_LIMIT_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            inject_reg <= inject_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                age_limit_reg <= cfg_data;
            end
        end
    end

    // Hold the transaction payload and the result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg <= seq_number;
            now_reg   <= now_time;
        end
        dup_reg  <= dup_next;
        ins_reg  <= ins_next;
        full_reg <= full_next;
        rem_reg  <= rem_next;
        rseq_reg <= rseq_next;
        occ_reg  <= occ_next;
    end

    assign done          = done_reg;
    assign is_duplicate  = dup_reg;
    assign was_inserted  = ins_reg;
    assign table_full    = full_reg;
    assign entry_removed = rem_reg;
    assign removed_seq   = rseq_reg;
    assign occupancy     = occ_reg;

endmodule

// ===== verif/flood_duplicate_filter_top_tb.sv =====
// Self-checking testbench for the flood duplicate filter: random traffic, age register sweeps.
`timescale 1ns / 1ps

module flood_duplicate_filter_top_tb;
    import fdf_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 240;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 4;

    typedef struct {
        logic              kind;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] now;
    } filter_item_t;

    typedef struct {
        logic              is_duplicate;
        logic              was_inserted;
        logic              table_full;
        logic              entry_removed;
        logic [SEQ_W-1:0]  removed_seq;
        logic [OCC_W-1:0]  occupancy;
    } filter_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              kind = KIND_CHECK;
    logic [SEQ_W-1:0]  seq_number = '0;
    logic [TIME_W-1:0] now_time = '0;
    logic              cfg_valid = 1'b0;
    logic [TIME_W-1:0] cfg_data = '0;
    logic              busy;
    logic              done;
    logic              is_duplicate;
    logic              was_inserted;
    logic              table_full;
    logic              entry_removed;
    logic [SEQ_W-1:0]  removed_seq;
    logic [OCC_W-1:0]  occupancy;
    logic              cfg_ready;

    // Transactions waiting for the driver and results waiting for the DUT
    filter_item_t   pending_items[$];
    filter_result_t expected_results[$];

    // Predicted table contents and age register
    logic [SEQ_W-1:0]  held_seq[TABLE_DEPTH];
    logic [TIME_W-1:0] held_time[TABLE_DEPTH];
    int                head_idx = 0;
    int                held_count = 0;
    logic [TIME_W-1:0] age_limit_model = AGE_LIMIT_RESET;

    // Handshake flags sampled at the rising edge, read at the falling edge
    logic item_taken = 1'b0;
    logic cfg_taken = 1'b0;

    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                gap_pct = 6;
    int                queued_count = 0;
    logic [TIME_W-1:0] sim_now = '0;
    logic [TIME_W-1:0] gen_age = AGE_LIMIT_RESET;
    logic [SEQ_W-1:0]  pool_base = '0;
    filter_item_t      next_item;
    filter_result_t    want_res;

    flood_duplicate_filter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .seq_number    (seq_number),
        .now_time      (now_time),
        .done          (done),
        .is_duplicate  (is_duplicate),
        .was_inserted  (was_inserted),
        .table_full    (table_full),
        .entry_removed (entry_removed),
        .removed_seq   (removed_seq),
        .occupancy     (occupancy),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%08h expected 0x%08h at cycle %0d",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Apply one transaction to the predicted table and return its result
    function automatic filter_result_t predict_filter(input filter_item_t it);
        filter_result_t    r;
        logic [TIME_W-1:0] age;
        int                slot;
        r = '{default: '0};
        if (it.kind == KIND_CHECK)
        begin
            for (int i = 0; i < held_count; i++)
                if (held_seq[(head_idx + i) % TABLE_DEPTH] == it.seq)
                    r.is_duplicate = 1'b1;
            if (!r.is_duplicate)
            begin
                if (held_count < TABLE_DEPTH)
                begin
                    slot = (head_idx + held_count) % TABLE_DEPTH;
                    held_seq[slot] = it.seq;
                    held_time[slot] = it.now;
                    held_count++;
                    r.was_inserted = 1'b1;
                end
                else
                    r.table_full = 1'b1;
            end
        end
        else if (held_count > 0)
        begin
            // Expire only the oldest entry, age taken modulo 2^32
            age = it.now - held_time[head_idx];
            if (age >= age_limit_model)
            begin
                r.entry_removed = 1'b1;
                r.removed_seq = held_seq[head_idx];
                head_idx = (head_idx + 1) % TABLE_DEPTH;
                held_count--;
            end
        end
        r.occupancy = OCC_W'(held_count);
        return r;
    endfunction

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Driver: present the next transaction at the falling edge, with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!start || item_taken))
        begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= gap_pct)
            begin
                next_item = pending_items.pop_front();
                start <= 1'b1;
                kind <= next_item.kind;
                seq_number <= next_item.seq;
                now_time <= next_item.now;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check results, then record accepted transactions and writes
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_taken <= 1'b0;
            cfg_taken <= 1'b0;
        end
        else
        begin
            item_taken <= start && !busy;
            cfg_taken <= cfg_valid && cfg_ready;
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with none pending", removed_seq, '0);
                else
                begin
                    want_res = expected_results.pop_front();
                    if (is_duplicate !== want_res.is_duplicate)
                        report_mismatch("is_duplicate", 32'(is_duplicate),
                                        32'(want_res.is_duplicate));
                    if (was_inserted !== want_res.was_inserted)
                        report_mismatch("was_inserted", 32'(was_inserted),
                                        32'(want_res.was_inserted));
                    if (table_full !== want_res.table_full)
                        report_mismatch("table_full", 32'(table_full),
                                        32'(want_res.table_full));
                    if (entry_removed !== want_res.entry_removed)
                        report_mismatch("entry_removed", 32'(entry_removed),
                                        32'(want_res.entry_removed));
                    if (removed_seq !== want_res.removed_seq)
                        report_mismatch("removed_seq", removed_seq, want_res.removed_seq);
                    if (occupancy !== want_res.occupancy)
                        report_mismatch("occupancy", 32'(occupancy),
                                        32'(want_res.occupancy));
                end
            end
            if (start && !busy)
                expected_results.insert(expected_results.size(),
                                        predict_filter('{kind, seq_number, now_time}));
            if (cfg_valid && cfg_ready)
                age_limit_model = cfg_data;
        end
    end

    task automatic queue_item(input logic k, input logic [SEQ_W-1:0] s,
                              input logic [TIME_W-1:0] t);
        filter_item_t item_rec;
        item_rec = '{k, s, t};
        pending_items.insert(pending_items.size(), item_rec);
        queued_count++;
    endtask

    // Hold until no transaction is waiting, in flight or on the ports
    task automatic wait_until_idle();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (pending_items.size() != 0 || expected_results.size() != 0 || start);
    endtask

    // Write the age register while the block is idle
    task automatic write_age_limit(input logic [TIME_W-1:0] value);
        wait_until_idle();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
        gen_age = value;
    endtask

    // Half from a small pool of repeats, most of the rest fresh numbers, some extremes
    function automatic logic [SEQ_W-1:0] pick_seq();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return pool_base + $urandom_range(0, 31);
        else if (roll == 9)
            return $urandom_range(0, 1) ? '1 : '0;
        return $urandom();
    endfunction

    // Advance the stimulus clock: small steps, full age steps, and jumps
    task automatic advance_time();
        case ($urandom_range(0, 9))
            0: sim_now = $urandom();
            1, 2: sim_now = sim_now + gen_age;
            default: sim_now = sim_now + $urandom_range(0, (gen_age >> 4) + 2);
        endcase
    endtask

    task automatic random_phase(input int n_items);
        int target;
        target = queued_count + n_items;
        pool_base = $urandom();
        while (queued_count < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    // Flood traffic: checks with repeats, ticks in between
                    repeat (20)
                    begin
                        advance_time();
                        if ($urandom_range(0, 99) < 65)
                            queue_item(KIND_CHECK, pick_seq(), sim_now);
                        else
                            queue_item(KIND_TICK, $urandom(), sim_now);
                    end
                end
                5, 6, 7:
                begin
                    // Fill past full, then let the oldest entries expire
                    repeat (TABLE_DEPTH + 6)
                    begin
                        sim_now = sim_now + $urandom_range(0, 3);
                        queue_item(KIND_CHECK, $urandom(), sim_now);
                    end
                    sim_now = sim_now + gen_age;
                    repeat (TABLE_DEPTH + 4)
                    begin
                        sim_now = sim_now + $urandom_range(0, 3);
                        queue_item(KIND_TICK, $urandom(), sim_now);
                    end
                end
                default:
                begin
                    // Noise: arbitrary kinds, numbers and times
                    repeat (10)
                        queue_item(1'($urandom_range(0, 1)), $urandom(), $urandom());
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty tick, duplicate, exact expiry edge, time wrap, extremes
        queue_item(KIND_TICK,  32'hDEAD_BEEF, 32'd0);
        queue_item(KIND_CHECK, 32'h0000_0000, 32'd0);
        queue_item(KIND_CHECK, 32'h0000_0000, 32'd5);
        queue_item(KIND_CHECK, 32'hFFFF_FFFF, 32'd100);
        queue_item(KIND_TICK,  32'h1234_5678, 32'd1999);
        queue_item(KIND_TICK,  32'hFFFF_FFFF, 32'd2000);
        queue_item(KIND_CHECK, 32'h0000_0000, 32'd2000);
        queue_item(KIND_TICK,  32'h0000_0000, 32'd2099);
        queue_item(KIND_TICK,  32'h0000_0001, 32'd2100);
        queue_item(KIND_CHECK, 32'hFFFF_FFFF, 32'd2100);
        queue_item(KIND_TICK,  32'h0000_0000, 32'd4000);
        queue_item(KIND_TICK,  32'h0000_0000, 32'd4100);
        queue_item(KIND_TICK,  32'h0000_0000, 32'd9999);
        queue_item(KIND_CHECK, 32'hA5A5_A5A5, 32'hFFFF_FF00);
        queue_item(KIND_CHECK, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
        queue_item(KIND_CHECK, 32'hA5A5_A5A5, 32'd3);
        queue_item(KIND_TICK,  32'h0000_0000, 32'h0000_06CF);
        queue_item(KIND_TICK,  32'h0000_0000, 32'h0000_06D0);
        queue_item(KIND_TICK,  32'h0000_0000, 32'h0000_07CF);
        sim_now = 32'h0000_07CF;
        random_phase(PHASE_ITEMS - 20);

        // Sweep the age register through its extremes and a few mid values
        write_age_limit(32'd1);
        random_phase(PHASE_ITEMS);
        write_age_limit(32'hFFFF_FFFF);
        random_phase(PHASE_ITEMS);
        gap_pct = 0;
        write_age_limit(32'd37);
        random_phase(PHASE_ITEMS);
        gap_pct = 6;
        write_age_limit($urandom_range(1, 32'hFFFF_FFFF));
        random_phase(PHASE_ITEMS);
        write_age_limit(AGE_LIMIT_RESET);
        random_phase(PHASE_ITEMS);

        // Drain, then allow time for any stray strobe
        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never produced", '0, expected_results.size());
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
